>>> src/meq_pkg.sv
// Shared types and constants for the masked-extract event queue.
package meq_pkg;

    localparam int TYPE_W = 5;
    localparam int DATA_W = 32;
    localparam int MASK_W = 32;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 6;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH    = 2'd0,
        FUNC_POP     = 2'd1,
        FUNC_EXTRACT = 2'd2
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Per-cell update controls: load takes the pushed entry, shift takes the
    // entry of the next younger neighbor.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

>>> src/meq_cell.sv
// One queue cell: holds one entry, flags a type-mask hit, and shifts from its neighbor.
module meq_cell (
    input  logic                       i_clk,
    input  meq_pkg::t_cell_ctl         i_ctl,
    input  logic                       i_valid,
    input  logic [meq_pkg::MASK_W-1:0] i_mask,
    input  logic [meq_pkg::TYPE_W-1:0] i_push_type,
    input  logic [meq_pkg::DATA_W-1:0] i_push_data,
    input  logic [meq_pkg::TYPE_W-1:0] i_next_type,
    input  logic [meq_pkg::DATA_W-1:0] i_next_data,
    output logic [meq_pkg::TYPE_W-1:0] o_type,
    output logic [meq_pkg::DATA_W-1:0] o_data,
    output logic                       o_hit
);

    logic [meq_pkg::TYPE_W-1:0] r_type;
    logic [meq_pkg::DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_type <= i_push_type;
            r_data <= i_push_data;
        end else if (i_ctl.shift) begin
            r_type <= i_next_type;
            r_data <= i_next_data;
        end
    end

    assign o_type = r_type;
    assign o_data = r_data;
    assign o_hit  = i_valid & i_mask[r_type];

endmodule

>>> src/meq_prefix_or.sv
// Log-depth inclusive prefix OR over the cell hit flags.
module meq_prefix_or #(
    parameter int WIDTH = 63
) (
    input  logic [WIDTH-1:0] i_bits,
    output logic [WIDTH-1:0] o_prefix
);

    localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 0;

    logic [WIDTH-1:0] w_lvl [0:LEVELS];

    assign w_lvl[0] = i_bits;

    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
        for (genvar i = 0; i < WIDTH; i++) begin : g_bit
            if (i >= (1 << l)) begin : g_or
                assign w_lvl[l+1][i] = w_lvl[l][i] | w_lvl[l][i-(1 << l)];
            end else begin : g_pass
                assign w_lvl[l+1][i] = w_lvl[l][i];
            end
        end
    end

    assign o_prefix = w_lvl[LEVELS];

endmodule

>>> src/masked_extract_event_queue.sv
// Top level of the masked-extract event queue built as a chain of entry cells.
//
// Usage: a transaction is accepted at a rising edge where start is high and
// busy is low. The request carries i_func (push, pop oldest, or extract the
// oldest entry whose type bit is set in i_type_mask), plus i_event_type and
// i_event_data for a push. The queue holds up to QUEUE_SLOTS-1 entries, kept
// oldest-first in a row of cells; removing an entry makes every younger cell
// take its neighbor's contents, so the order is kept.
//
// Timing: the request is registered on acceptance, busy is high in the
// execute cycle in which all cells test the mask in parallel and the chain
// shifts, and the result appears on the output ports for exactly one cycle,
// marked by o_valid, in the cycle after that. A new transaction can be
// accepted in that same result cycle, but not while the one before it is
// still executing; the execute cycle holds the prefix search over the cell
// hit flags.
//
// Reset (synchronous, active low) empties the queue and clears the control
// state. The receiver cannot stall the result; it must take it when o_valid
// is high. The occupancy field reports the low six bits of the entry count.
module masked_extract_event_queue #(
    parameter int QUEUE_SLOTS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [meq_pkg::FUNC_W-1:0] i_func,
    input  logic [meq_pkg::TYPE_W-1:0] i_event_type,
    input  logic [meq_pkg::DATA_W-1:0] i_event_data,
    input  logic [meq_pkg::MASK_W-1:0] i_type_mask,
    output logic                       o_valid,
    output logic [meq_pkg::STAT_W-1:0] o_status,
    output logic [meq_pkg::TYPE_W-1:0] o_out_type,
    output logic [meq_pkg::DATA_W-1:0] o_out_data,
    output logic [meq_pkg::OCC_W-1:0]  o_occupancy
);

    // Number of cells, and the width of a count that reaches it.
    localparam int NCELL = QUEUE_SLOTS - 1;
    localparam int CNT_W = $clog2(QUEUE_SLOTS);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NCELL);

    // Control state.
    meq_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;

    // Registered request.
    logic [meq_pkg::FUNC_W-1:0] r_func;
    logic [meq_pkg::TYPE_W-1:0] r_type;
    logic [meq_pkg::DATA_W-1:0] r_data;
    logic [meq_pkg::MASK_W-1:0] r_mask;

    // Result registers.
    logic                       r_valid, n_valid;
    logic [meq_pkg::STAT_W-1:0] r_status, n_status;
    logic [meq_pkg::TYPE_W-1:0] r_out_type, n_out_type;
    logic [meq_pkg::DATA_W-1:0] r_out_data, n_out_data;

    // Cell row signals.
    logic [meq_pkg::TYPE_W-1:0] w_cell_type [NCELL];
    logic [meq_pkg::DATA_W-1:0] w_cell_data [NCELL];
    meq_pkg::t_cell_ctl         w_ctl       [NCELL];
    logic [NCELL-1:0]           w_hit;
    logic [NCELL-1:0]           w_incl;
    logic [NCELL-1:0]           w_first;
    logic [NCELL-1:0]           w_shift_zone;

    logic w_accept;
    logic w_exec;
    logic w_push_ok;
    logic w_remove;
    logic w_any_hit;
    logic w_is_extract;
    logic [meq_pkg::TYPE_W-1:0] w_rm_type;
    logic [meq_pkg::DATA_W-1:0] w_rm_data;
    logic [CNT_W+meq_pkg::OCC_W-1:0] w_occ_ext;

    assign busy     = (r_state == meq_pkg::S_EXEC);
    assign w_accept = start & ~busy;
    assign w_exec   = (r_state == meq_pkg::S_EXEC);

    // Capture the request when it is accepted.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_func;
            r_type <= i_event_type;
            r_data <= i_event_data;
            r_mask <= i_type_mask;
        end
    end

    // The row of cells. Cells below the entry count hold live entries; the
    // youngest cell shifts in don't-care contents, which lie beyond the count.
    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        logic [meq_pkg::TYPE_W-1:0] w_next_type;
        logic [meq_pkg::DATA_W-1:0] w_next_data;
        logic                       w_live;

        if (i == NCELL - 1) begin : g_last
            assign w_next_type = '0;
            assign w_next_data = '0;
        end else begin : g_mid
            assign w_next_type = w_cell_type[i+1];
            assign w_next_data = w_cell_data[i+1];
        end

        assign w_live         = (CNT_W'(i) < r_count);
        assign w_ctl[i].load  = w_exec & w_push_ok & (r_count == CNT_W'(i));
        assign w_ctl[i].shift = w_exec & w_remove & w_shift_zone[i];

        meq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl[i]),
            .i_valid     (w_live),
            .i_mask      (r_mask),
            .i_push_type (r_type),
            .i_push_data (r_data),
            .i_next_type (w_next_type),
            .i_next_data (w_next_data),
            .o_type      (w_cell_type[i]),
            .o_data      (w_cell_data[i]),
            .o_hit       (w_hit[i])
        );
    end

    // Oldest hit: the first cell whose inclusive prefix turns on.
    meq_prefix_or #(
        .WIDTH (NCELL)
    ) u_prefix (
        .i_bits   (w_hit),
        .o_prefix (w_incl)
    );

    assign w_first      = w_incl & ~(w_incl << 1);
    assign w_any_hit    = w_incl[NCELL-1];
    assign w_is_extract = (r_func == meq_pkg::FUNC_EXTRACT);

    // A pop removes cell zero, so every cell shifts; an extract shifts the
    // matched cell and all younger ones.
    assign w_shift_zone = w_is_extract ? w_incl : {NCELL{1'b1}};

    // The removed entry, selected with the one-hot first-hit vector for an
    // extract or taken from the oldest cell for a pop.
    always_comb begin
        w_rm_type = '0;
        w_rm_data = '0;
        if (w_is_extract) begin
            for (int i = 0; i < NCELL; i++) begin
                w_rm_type = w_rm_type | (w_cell_type[i] & {meq_pkg::TYPE_W{w_first[i]}});
                w_rm_data = w_rm_data | (w_cell_data[i] & {meq_pkg::DATA_W{w_first[i]}});
            end
        end else begin
            w_rm_type = w_cell_type[0];
            w_rm_data = w_cell_data[0];
        end
    end

    // Next state, count and result.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_out_type = r_out_type;
        n_out_data = r_out_data;
        w_push_ok  = 1'b0;
        w_remove   = 1'b0;
        case (r_state)
            meq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = meq_pkg::S_EXEC;
                end
            end
            meq_pkg::S_EXEC: begin
                n_state    = meq_pkg::S_IDLE;
                n_valid    = 1'b1;
                n_status   = meq_pkg::ST_NONE;
                n_out_type = '0;
                n_out_data = '0;
                case (r_func)
                    meq_pkg::FUNC_PUSH: begin
                        if (r_count == FULL_CNT) begin
                            n_status = meq_pkg::ST_FULL;
                        end else begin
                            w_push_ok = 1'b1;
                            n_count   = r_count + CNT_W'(1);
                            n_status  = meq_pkg::ST_OK;
                        end
                    end
                    meq_pkg::FUNC_POP: begin
                        if (r_count != '0) begin
                            w_remove = 1'b1;
                        end
                    end
                    meq_pkg::FUNC_EXTRACT: begin
                        if (w_any_hit) begin
                            w_remove = 1'b1;
                        end
                    end
                    default: begin
                        w_remove = 1'b0;
                    end
                endcase
                if (w_remove) begin
                    n_count    = r_count - CNT_W'(1);
                    n_status   = meq_pkg::ST_OK;
                    n_out_type = w_rm_type;
                    n_out_data = w_rm_data;
                end
            end
            default: begin
                n_state = meq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= meq_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_out_type <= n_out_type;
        r_out_data <= n_out_data;
    end

    assign w_occ_ext   = {{meq_pkg::OCC_W{1'b0}}, r_count};
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_out_type  = r_out_type;
    assign o_out_data  = r_out_data;
    assign o_occupancy = w_occ_ext[meq_pkg::OCC_W-1:0];

`ifndef SYNTHESIS
    // At most one cell is picked as the oldest match.
    a_first_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("more than one cell selected for extract");

    // The entry count never exceeds the number of cells.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond capacity");

    // The count only moves at the end of an execute cycle.
    a_count_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> $past(w_exec))
        else $error("entry count changed outside execute");

    // Every execute cycle produces a result strobe.
    a_valid_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> r_valid)
        else $error("execute cycle produced no result");
`endif

endmodule

>>> test/masked_extract_event_queue_tb.sv
// Self-checking testbench for the masked-extract event queue: directed and random requests.
module masked_extract_event_queue_tb;

    // Field widths, taken from the shared package.
    localparam int FUNC_W = meq_pkg::FUNC_W;
    localparam int TYPE_W = meq_pkg::TYPE_W;
    localparam int DATA_W = meq_pkg::DATA_W;
    localparam int MASK_W = meq_pkg::MASK_W;
    localparam int STAT_W = meq_pkg::STAT_W;
    localparam int OCC_W  = meq_pkg::OCC_W;

    // The queue is built with its default depth. It holds one entry fewer than it has slots.
    localparam int SLOTS = 64;
    localparam int RANDOM_REQUESTS = 1600;
    localparam int LIMIT_CYCLES = 200000;
    // A result leaves the block after the execute state and the result registers. The tail
    // wait runs on past that, so that a stray result after the last expected one is caught.
    localparam int TAIL_CYCLES = 8;
    localparam int PRINT_CAP = 40;

    // Function code 3 is not an operation. The block must answer it as a miss and leave
    // its contents alone.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [TYPE_W-1:0] kind;
        logic [DATA_W-1:0] payload;
    } t_entry;

    typedef struct packed {
        meq_pkg::t_status  status;
        logic [TYPE_W-1:0] kind;
        logic [DATA_W-1:0] payload;
        logic [OCC_W-1:0]  occupancy;
    } t_outcome;

    // The ledger mirrors the queue contents, oldest entry first. It predicts the outcome of
    // every accepted transaction and matches each result strobe against the oldest outcome
    // still outstanding.
    class event_ledger;
        t_entry   held[$];
        t_outcome outstanding_outcomes[$];
        int       mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        task flag_mismatch(input string what);
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP)
                $display("mismatch: %s", what);
        endtask

        function int outstanding();
            return outstanding_outcomes.size();
        endfunction

        function void note_request(input logic [FUNC_W-1:0] func,
                                   input logic [TYPE_W-1:0] kind,
                                   input logic [DATA_W-1:0] payload,
                                   input logic [MASK_W-1:0] mask);
            t_outcome o;
            t_entry   e;
            int       hit;
            o.status = meq_pkg::ST_NONE;
            o.kind = '0;
            o.payload = '0;
            hit = -1;
            case (func)
                meq_pkg::FUNC_PUSH: begin
                    if (held.size() >= SLOTS - 1) begin
                        o.status = meq_pkg::ST_FULL;
                    end else begin
                        e.kind = kind;
                        e.payload = payload;
                        held.push_back(e);
                        o.status = meq_pkg::ST_OK;
                    end
                end
                meq_pkg::FUNC_POP: begin
                    if (held.size() != 0)
                        hit = 0;
                end
                meq_pkg::FUNC_EXTRACT: begin
                    foreach (held[k])
                        if (hit < 0 && mask[held[k].kind])
                            hit = k;
                end
                default: ;
            endcase
            // A removal closes the gap; the queue delete keeps the younger entries in order.
            if (hit >= 0) begin
                o.status = meq_pkg::ST_OK;
                o.kind = held[hit].kind;
                o.payload = held[hit].payload;
                held.delete(hit);
            end
            o.occupancy = OCC_W'(held.size());
            outstanding_outcomes.push_back(o);
        endfunction

        task check_result(input logic [STAT_W-1:0] status,
                          input logic [TYPE_W-1:0] kind,
                          input logic [DATA_W-1:0] payload,
                          input logic [OCC_W-1:0]  occupancy);
            t_outcome o;
            if (outstanding_outcomes.size() == 0) begin
                flag_mismatch($sformatf("result status %0d with no transaction outstanding",
                                        status));
            end else begin
                o = outstanding_outcomes.pop_front();
                if (status !== o.status)
                    flag_mismatch($sformatf("status %0d, expected %0d", status, o.status));
                if (kind !== o.kind)
                    flag_mismatch($sformatf("type %0d, expected %0d", kind, o.kind));
                if (payload !== o.payload)
                    flag_mismatch($sformatf("data %h, expected %h", payload, o.payload));
                if (occupancy !== o.occupancy)
                    flag_mismatch($sformatf("occupancy %0d, expected %0d",
                                            occupancy, o.occupancy));
            end
        endtask
    endclass

    // Every input has a known value from time zero.
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [FUNC_W-1:0]   i_func = '0;
    logic [TYPE_W-1:0]   i_event_type = '0;
    logic [DATA_W-1:0]   i_event_data = '0;
    logic [MASK_W-1:0]   i_type_mask = '0;
    logic                o_valid;
    logic [STAT_W-1:0]   o_status;
    logic [TYPE_W-1:0]   o_out_type;
    logic [DATA_W-1:0]   o_out_data;
    logic [OCC_W-1:0]    o_occupancy;

    event_ledger book;
    int          sender_idle_pct = 0;
    int          push_bias_pct = 85;
    int          bias_run_left = 0;
    int          cycle_count = 0;

    masked_extract_event_queue #(
        .QUEUE_SLOTS(SLOTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_event_type(i_event_type),
        .i_event_data(i_event_data),
        .i_type_mask (i_type_mask),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_out_type  (o_out_type),
        .o_out_data  (o_out_data),
        .o_occupancy (o_occupancy)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Presents one transaction and returns at the edge that accepts it. All driving
    // happens at a rising edge, so the block and this task agree on what that edge saw.
    // When the sender idles, start drops and the payload ports carry junk. The gap has a random
    // length; it covers the execute cycle of the transaction before it and, when long enough,
    // its result cycle too. Without a gap, start stays high and
    // the next request follows back to back.
    task automatic issue(input logic [FUNC_W-1:0] func,
                         input logic [TYPE_W-1:0] kind,
                         input logic [DATA_W-1:0] payload,
                         input logic [MASK_W-1:0] mask);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            i_func <= FUNC_W'($urandom);
            i_event_type <= TYPE_W'($urandom);
            i_event_data <= $urandom;
            i_type_mask <= $urandom;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= func;
        i_event_type <= kind;
        i_event_data <= payload;
        i_type_mask <= mask;
        do @(posedge i_clk); while (busy !== 1'b0);
        book.note_request(func, kind, payload, mask);
    endtask

    // Builds one random request. The generator alternates between fill runs and drain runs.
    // A fill run is mostly pushes, aimed at taking the queue up to full and past it. A drain run
    // is mostly removals, aimed at emptying it and removing from it while empty. The event types
    // come often from two narrow groups, so extracts find several candidates and must pick
    // the oldest. The masks are random words, single bits, zero, all ones, or the type of
    // an entry that the queue holds.
    task automatic random_request();
        logic [FUNC_W-1:0] func;
        logic [TYPE_W-1:0] kind;
        logic [MASK_W-1:0] mask;
        int                pick;
        if (bias_run_left == 0) begin
            push_bias_pct = (push_bias_pct > 50) ? 15 : 85;
            bias_run_left = $urandom_range(60, 200);
        end
        bias_run_left--;

        pick = $urandom_range(99);
        if (pick < 2)
            func = FUNC_UNUSED;
        else if ($urandom_range(99) < push_bias_pct)
            func = meq_pkg::FUNC_PUSH;
        else if ($urandom_range(1) == 0)
            func = meq_pkg::FUNC_POP;
        else
            func = meq_pkg::FUNC_EXTRACT;

        if ($urandom_range(1) == 0)
            kind = TYPE_W'($urandom_range(0, 31));
        else
            kind = TYPE_W'($urandom_range(0, 3) + (($urandom_range(1) != 0) ? 28 : 0));

        case ($urandom_range(5))
            0: mask = $urandom;
            1: mask = MASK_W'(1) << $urandom_range(0, 31);
            2: mask = '0;
            3: mask = '1;
            default: begin
                if (book.held.size() != 0)
                    mask = MASK_W'(1) << book.held[$urandom_range(0, book.held.size() - 1)].kind;
                else
                    mask = $urandom;
            end
        endcase
        issue(func, kind, $urandom, mask);
    endtask

    // Results cannot be held off, so every strobe is checked at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            book.check_result(o_status, o_out_type, o_out_data, o_occupancy);
    end

    // A hung handshake or a missing result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        book = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Both empty-queue misses and the unused code on an empty queue come
        // first. Then come pushes with the extreme types and payloads. A zero mask misses,
        // and an extract from the middle shows that the younger entries close the gap in
        // order. An extract on a repeated type must take the older copy. The unused code must
        // leave a filled queue intact. Extracts and a pop then drain the queue, a last pop finds it
        // empty, and a final extract finds it empty too.
        issue(meq_pkg::FUNC_POP, '0, '0, '0);
        issue(meq_pkg::FUNC_EXTRACT, '1, '1, '1);
        issue(FUNC_UNUSED, '1, '1, '1);
        issue(meq_pkg::FUNC_PUSH, 5'd0, 32'h0000_0000, '1);
        issue(meq_pkg::FUNC_PUSH, 5'd31, 32'hFFFF_FFFF, '0);
        issue(meq_pkg::FUNC_PUSH, 5'd5, 32'hA5A5_A5A5, '0);
        issue(meq_pkg::FUNC_PUSH, 5'd31, 32'h5A5A_5A5A, '0);
        issue(meq_pkg::FUNC_PUSH, 5'd10, 32'h1234_5678, '0);
        issue(meq_pkg::FUNC_EXTRACT, '0, '0, 32'h0000_0000);
        issue(meq_pkg::FUNC_EXTRACT, '0, '0, 32'h7FFF_FBDE);
        issue(meq_pkg::FUNC_EXTRACT, '0, '0, 32'h0000_0020);
        issue(meq_pkg::FUNC_EXTRACT, '0, '0, 32'h8000_0000);
        issue(FUNC_UNUSED, 5'd7, 32'hDEAD_BEEF, '1);
        issue(meq_pkg::FUNC_EXTRACT, '0, '0, 32'h0000_0001);
        issue(meq_pkg::FUNC_POP, '1, '1, '1);
        issue(meq_pkg::FUNC_EXTRACT, '0, '0, 32'h0000_0400);
        issue(meq_pkg::FUNC_POP, '0, '0, '0);
        issue(meq_pkg::FUNC_EXTRACT, '0, '0, '1);

        // Random part. The sender idles often at first, then very often, then never.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n < RANDOM_REQUESTS / 3)
                sender_idle_pct = 31;
            else if (n < 2 * RANDOM_REQUESTS / 3)
                sender_idle_pct = 81;
            else
                sender_idle_pct = 0;
            random_request();
        end
        start <= 1'b0;

        while (book.outstanding() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (book.mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
